/* rtl/core/txs_pkg.sv */
// txs_pkg: shared types and constants for the 3x3 text outline smoother
// used by every module under rtl/core; depends on nothing else
`timescale 1ns / 1ps

package txs_pkg;

	// configuration register indexes
	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	// register reset values and field widths
	localparam int unsigned SIZE_W      = 11;
	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd64;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd64;
	localparam int unsigned PIX_W = 8;
	localparam int unsigned POS_W = 10;

	// up to three results per input beat
	localparam int unsigned RES_MAX = 3;

	// one result beat
	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic             last;
	} txs_res_t;

	typedef txs_res_t [RES_MAX-1:0] txs_set_t;

	// one accepted pixel with its position and the edge flags of that position
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] col_m1;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] row_m1;
		logic             r_ge1;
		logic             c_ge1;
		logic             c_last;
		logic             r_last;
		logic             r_one;
		logic             c_one;
	} txs_pos_t;

endpackage

/* rtl/core/text_outline_3x3_smoother.sv */
// text_outline_3x3_smoother: top level, configuration, raster position and stage control
// depends on txs_pkg, txs_linebuf, txs_kernel, txs_emit
`timescale 1ns / 1ps

// Smooths one frame of 8-bit coverage pixels streamed in raster order.
// Channels: pixel beats on in_valid/in_ready, result beats (value, column,
// row, last) on out_valid/out_ready, register writes on cfg_valid/cfg_ready
// (index 0 frame width, index 1 frame height, sizes clamped to 3..MAX).
// Each pixel gives zero to three results: the interior neighbor up and left,
// the pixel above at the last column, and the pixel itself on the last row.
// Results therefore trail the input by one row and one column; last marks
// the final result of the frame.
// The first result of a pixel passes the stage 1 register and then the
// result register before it is valid on the output.
// Throughput: the output moves one result per cycle while out_ready is
// high; a new pixel enters the result register only once the results of
// the pixel before it are gone or the only pending one leaves. The row
// stores take one read and one write a cycle.
// Reset clears the position to row 0, column 0, the sizes to 64 and all
// valid state; row store contents are not cleared and need no sweep.
// An output stall holds the pending results; one more pixel is taken and
// parked, then in_ready drops until the output frees up.
// Registers are to be written only while idle; the user must keep to this, the block does not enforce it.
module text_outline_3x3_smoother #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [0:0]                 cfg_index,
	input  logic [txs_pkg::SIZE_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [txs_pkg::PIX_W-1:0]  pixel,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [txs_pkg::PIX_W-1:0]  value,
	output logic [txs_pkg::POS_W-1:0]  column,
	output logic [txs_pkg::POS_W-1:0]  row,
	output logic                       last
);
	import txs_pkg::*;

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);

	logic [SIZE_W-1:0] width_q, height_q;
	logic [CW-1:0]     col_q, wlast, cur_c, c_m1;
	logic [RW-1:0]     row_q, hlast, cur_r, r_m1;
	logic [31:0]       wext, hext;
	logic              accept, advance, load_ok, s1_valid;
	logic              at_clast, at_rlast;
	logic [CW-1:0]     addr_s1;
	txs_pos_t          pos_s1;
	logic [PIX_W-1:0]  top_s1, mid_s1;
	txs_set_t          res_set;
	logic [RES_MAX-1:0] res_vld;
	txs_res_t          out_res;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// last column and last row after clamping the sizes
	always_comb begin
		wext = 32'(width_q);
		hext = 32'(height_q);
		if (wext < 32'd3) begin
			wlast = CW'(2);
		end else if (wext > 32'(MAX_WIDTH)) begin
			wlast = CW'(MAX_WIDTH - 1);
		end else begin
			wlast = CW'(wext - 32'd1);
		end
		if (hext < 32'd3) begin
			hlast = RW'(2);
		end else if (hext > 32'(MAX_HEIGHT)) begin
			hlast = RW'(MAX_HEIGHT - 1);
		end else begin
			hlast = RW'(hext - 32'd1);
		end
	end

	// position of the incoming pixel, held inside the frame
	assign cur_c    = (col_q > wlast) ? wlast : col_q;
	assign cur_r    = (row_q > hlast) ? hlast : row_q;
	assign c_m1     = cur_c - CW'(1);
	assign r_m1     = cur_r - RW'(1);
	assign at_clast = (cur_c == wlast);
	assign at_rlast = (cur_r == hlast);

	// stage handshake
	assign advance  = s1_valid && load_ok;
	assign in_ready = !s1_valid || load_ok;
	assign accept   = in_valid && in_ready;

	// raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (at_clast) begin
				col_q <= '0;
				row_q <= at_rlast ? '0 : cur_r + RW'(1);
			end else begin
				col_q <= cur_c + CW'(1);
				row_q <= cur_r;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	// stage 1 payload: pixel, position and edge flags
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1       <= cur_c;
			pos_s1.pixel  <= pixel;
			pos_s1.col    <= POS_W'(cur_c);
			pos_s1.col_m1 <= POS_W'(c_m1);
			pos_s1.row    <= POS_W'(cur_r);
			pos_s1.row_m1 <= POS_W'(r_m1);
			pos_s1.r_ge1  <= (cur_r != '0);
			pos_s1.c_ge1  <= (cur_c != '0);
			pos_s1.c_last <= at_clast;
			pos_s1.r_last <= at_rlast;
			pos_s1.r_one  <= (cur_r == RW'(1));
			pos_s1.c_one  <= (cur_c == CW'(1));
		end
	end

	txs_linebuf #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (CW)
	) u_linebuf (
		.clk      (clk),
		.rd_en    (accept),
		.rd_addr  (cur_c),
		.new_data (pixel),
		.old_we   (advance),
		.old_addr (addr_s1),
		.old_data (mid_s1),
		.top_s1   (top_s1),
		.mid_s1   (mid_s1)
	);

	txs_kernel u_kernel (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.pos_s1  (pos_s1),
		.top_s1  (top_s1),
		.mid_s1  (mid_s1),
		.res_set (res_set),
		.res_vld (res_vld)
	);

	txs_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res_set   (res_set),
		.res_vld   (res_vld),
		.load_ok   (load_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign value  = out_res.value;
	assign column = out_res.column;
	assign row    = out_res.row;
	assign last   = out_res.last;

endmodule

/* rtl/core/txs_linebuf.sv */
// txs_linebuf: the two row stores, row r-2 and row r-1, one entry per column
// read data registered; depends on txs_pkg
`timescale 1ns / 1ps

module txs_linebuf #(
	parameter int unsigned DEPTH  = 1024,
	parameter int unsigned ADDR_W = 10
) (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [ADDR_W-1:0]         rd_addr,
	input  logic [txs_pkg::PIX_W-1:0] new_data,
	input  logic                      old_we,
	input  logic [ADDR_W-1:0]         old_addr,
	input  logic [txs_pkg::PIX_W-1:0] old_data,
	output logic [txs_pkg::PIX_W-1:0] top_s1,
	output logic [txs_pkg::PIX_W-1:0] mid_s1
);
	import txs_pkg::*;

	logic [PIX_W-1:0] older_mem [DEPTH];
	logic [PIX_W-1:0] newer_mem [DEPTH];

	// read both rows at the incoming column, store the new pixel in its place
	always_ff @(posedge clk) begin
		if (rd_en) begin
			top_s1 <= older_mem[rd_addr];
			mid_s1 <= newer_mem[rd_addr];
			newer_mem[rd_addr] <= new_data;
		end
	end

	// the row that was newer moves to the older store when its pixel leaves stage 1
	always_ff @(posedge clk) begin
		if (old_we) begin
			older_mem[old_addr] <= old_data;
		end
	end

endmodule

/* rtl/core/txs_kernel.sv */
// txs_kernel: 3x3 window registers and the center weighted filter
// builds the result set of one pixel; depends on txs_pkg
`timescale 1ns / 1ps

module txs_kernel (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  txs_pkg::txs_pos_t         pos_s1,
	input  logic [txs_pkg::PIX_W-1:0] top_s1,
	input  logic [txs_pkg::PIX_W-1:0] mid_s1,
	output txs_pkg::txs_set_t         res_set,
	output logic [txs_pkg::RES_MAX-1:0] res_vld
);
	import txs_pkg::*;

	// [0],[1] top row at c-2,c-1; [2],[3] middle row; [4],[5] bottom row
	logic [PIX_W-1:0] win_q [6];
	logic [PIX_W+3:0] sum;
	logic [PIX_W-1:0] filt;
	logic [1:0]       cnt;

	// window shifts by one column per pixel leaving the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (advance) begin
			win_q[0] <= win_q[1];
			win_q[1] <= top_s1;
			win_q[2] <= win_q[3];
			win_q[3] <= mid_s1;
			win_q[4] <= win_q[5];
			win_q[5] <= pos_s1.pixel;
		end
	end

	// weight eight on the center, one on each neighbor
	always_comb begin
		sum = {1'b0, win_q[3], 3'b000}
			+ 12'(win_q[0]) + 12'(win_q[1]) + 12'(top_s1)
			+ 12'(win_q[2]) + 12'(mid_s1)
			+ 12'(win_q[4]) + 12'(win_q[5]) + 12'(pos_s1.pixel);
		if (pos_s1.r_one) begin
			filt = '0;
		end else if (pos_s1.c_one) begin
			filt = win_q[3];
		end else begin
			filt = sum[PIX_W+3:4];
		end
	end

	// collect the results in emission order
	always_comb begin
		res_set = '0;
		cnt     = 2'd0;
		if (pos_s1.r_ge1 && pos_s1.c_ge1) begin
			res_set[cnt] = '{value: filt, column: pos_s1.col_m1, row: pos_s1.row_m1,
				last: 1'b0};
			cnt = cnt + 2'd1;
		end
		if (pos_s1.r_ge1 && pos_s1.c_last) begin
			res_set[cnt] = '{value: (pos_s1.r_one ? '0 : mid_s1), column: pos_s1.col,
				row: pos_s1.row_m1, last: 1'b0};
			cnt = cnt + 2'd1;
		end
		if (pos_s1.r_last) begin
			res_set[cnt] = '{value: pos_s1.pixel, column: pos_s1.col, row: pos_s1.row,
				last: pos_s1.c_last};
			cnt = cnt + 2'd1;
		end
		case (cnt)
			2'd0:    res_vld = 3'b000;
			2'd1:    res_vld = 3'b001;
			2'd2:    res_vld = 3'b011;
			default: res_vld = 3'b111;
		endcase
	end

endmodule

/* rtl/core/txs_emit.sv */
// txs_emit: result register that hands out the results of one pixel a beat at a time
// depends on txs_pkg
`timescale 1ns / 1ps

module txs_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  txs_pkg::txs_set_t           res_set,
	input  logic [txs_pkg::RES_MAX-1:0] res_vld,
	output logic                        load_ok,
	output logic                        out_valid,
	input  logic                        out_ready,
	output txs_pkg::txs_res_t           out_res
);
	import txs_pkg::*;

	txs_set_t           res_s2;
	logic [RES_MAX-1:0] vld_s2;
	logic               take;

	assign out_valid = vld_s2[0];
	assign out_res   = res_s2[0];
	assign take      = out_valid && out_ready;
	// free when empty or when the only pending beat leaves now
	assign load_ok   = !vld_s2[1] && (!vld_s2[0] || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= '0;
		end else if (load) begin
			vld_s2 <= res_vld;
		end else if (take) begin
			vld_s2 <= vld_s2 >> 1;
		end
	end

	// payload shifts toward the output slot
	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_set;
		end else if (take) begin
			res_s2 <= {res_s2[2], res_s2[2], res_s2[1]};
		end
	end

endmodule

/* rtl/core/txs_checker.sv */
// txs_checker: port level checks for the text outline smoother, bound to the top level
// depends on txs_pkg and text_outline_3x3_smoother
`timescale 1ns / 1ps

module txs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_valid,
	input logic                       cfg_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [txs_pkg::PIX_W-1:0]  value,
	input logic [txs_pkg::POS_W-1:0]  column,
	input logic [txs_pkg::POS_W-1:0]  row,
	input logic                       last
);
	import txs_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({value, column, row, last}))
		else $error("result beat changed while stalled");

	// nothing leaves while or right after reset is applied
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result beat during reset");

	// the top row is always emitted as zero
	a_row0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row == '0 |-> value == '0 && !last)
		else $error("nonzero result on row 0");

	// register writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

endmodule

bind text_outline_3x3_smoother txs_checker u_txs_checker (.*);

/* dv/text_outline_3x3_smoother_test.sv */
// text_outline_3x3_smoother_test: self-checking bench for the 3x3 text outline smoother
// streams whole frames at several sizes and checks every result beat against a local model
// depends on txs_pkg and the text_outline_3x3_smoother rtl
`timescale 1ns / 1ps

module text_outline_3x3_smoother_test;

	import txs_pkg::*;

	localparam int unsigned MAX_W = 1024;
	localparam int unsigned MAX_H = 1024;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned RANDOM_PIXELS = 60;

	typedef enum {FILL_RANDOM, FILL_FULL, FILL_EMPTY, FILL_CHECKER} fill_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [0:0]        cfg_index = REG_WIDTH;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [PIX_W-1:0]  pixel = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [PIX_W-1:0]  res_value;
	logic [POS_W-1:0]  res_column;
	logic [POS_W-1:0]  res_row;
	logic              res_last;

	// handshakes seen at the last rising edge
	bit pix_acc = 1'b0;
	bit res_acc = 1'b0;
	bit cfg_acc = 1'b0;

	// local copy of the smoother state
	logic [SIZE_W-1:0] width_reg = WIDTH_RESET;
	logic [SIZE_W-1:0] height_reg = HEIGHT_RESET;
	logic [PIX_W-1:0]  older_line [0:MAX_W-1];
	logic [PIX_W-1:0]  newer_line [0:MAX_W-1];
	logic [PIX_W-1:0]  win [0:5];
	int unsigned       col_pos = 0;
	int unsigned       row_pos = 0;

	logic [PIX_W-1:0] pixel_backlog [$];
	txs_res_t         smoothed_due [$];
	int unsigned      pixels_queued = 0;
	int unsigned      pixels_taken = 0;
	int unsigned      mismatches = 0;
	int unsigned      cycle_count = 0;
	int unsigned      src_hold = 0;
	int unsigned      sink_hold = 0;
	bit               src_quiet = 1'b0;
	bit               sink_quiet = 1'b0;

	text_outline_3x3_smoother #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.pixel    (pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value    (res_value),
		.column   (res_column),
		.row      (res_row),
		.last     (res_last)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// frame size as the block sees it
	function automatic int unsigned size_limit(input logic [SIZE_W-1:0] v, input int unsigned hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void push_result(input logic [PIX_W-1:0] v, input int unsigned c,
		input int unsigned r, input bit lst);
		txs_res_t e;
		e.value  = v;
		e.column = c[POS_W-1:0];
		e.row    = r[POS_W-1:0];
		e.last   = lst;
		smoothed_due.push_back(e);
	endfunction

	// results caused by one pixel beat, then the state update
	function automatic void smooth_pixel(input logic [PIX_W-1:0] b);
		int unsigned w, h, c, r, s;
		logic [PIX_W-1:0] t, m;
		w = size_limit(width_reg, MAX_W);
		h = size_limit(height_reg, MAX_H);
		c = (col_pos < w) ? col_pos : w - 1;
		r = (row_pos < h) ? row_pos : h - 1;
		t = older_line[c];
		m = newer_line[c];

		// pixel up and left: zero on the top row, passed on the first column
		if (r >= 1 && c >= 1) begin
			if (r == 1)
				s = 0;
			else if (c == 1)
				s = win[3];
			else
				s = (8 * win[3] + win[0] + win[1] + t + win[2] + m + win[4] + win[5] + b) / 16;
			push_result(s[PIX_W-1:0], c - 1, r - 1, 1'b0);
		end
		// pixel above at the last column
		if (r >= 1 && c == w - 1)
			push_result((r == 1) ? 8'h00 : m, c, r - 1, 1'b0);
		// last row passes straight through
		if (r == h - 1)
			push_result(b, c, r, c == w - 1);

		win[0] = win[1];
		win[2] = win[3];
		win[4] = win[5];
		win[1] = t;
		win[3] = m;
		win[5] = b;
		older_line[c] = m;
		newer_line[c] = b;

		if (c == w - 1) begin
			col_pos = 0;
			row_pos = (r == h - 1) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endfunction

	function automatic void compare_field(input string what, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
		end
	endfunction

	// monitor: register writes, pixel beats into the model, result beats against it
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: no progress, run stopped", $time);
			$display("*** FAILED ***");
			$finish;
		end else begin
			cfg_acc = arst_n && cfg_valid && cfg_ready;
			pix_acc = arst_n && in_valid && in_ready;
			res_acc = arst_n && out_valid && out_ready;
			if (cfg_acc) begin
				if (cfg_index == REG_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
			end
			if (pix_acc) begin
				smooth_pixel(pixel);
				pixels_taken++;
			end
			if (res_acc) begin
				if (smoothed_due.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with nothing expected: value %0d column %0d row %0d last %0d",
						$time, res_value, res_column, res_row, res_last);
				end else begin
					txs_res_t e;
					e = smoothed_due.pop_front();
					compare_field("value", e.value, res_value);
					compare_field("column", e.column, res_column);
					compare_field("row", e.row, res_row);
					compare_field("last", e.last, res_last);
				end
			end
		end
	end

	// pixel driver: one beat per queued pixel, random gap after each
	always @(negedge clk) begin
		if (arst_n && (!in_valid || pix_acc)) begin
			if (src_hold > 0) begin
				src_hold--;
				in_valid <= 1'b0;
			end else if (pixel_backlog.size() != 0) begin
				pixel <= pixel_backlog.pop_front();
				in_valid <= 1'b1;
				if ($urandom_range(0, 31) == 0)
					src_quiet = !src_quiet;
				src_hold = src_quiet ? 0 : $urandom_range(0, 16);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result sink: random stall after each accepted beat
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_acc) begin
				if ($urandom_range(0, 31) == 0)
					sink_quiet = !sink_quiet;
				sink_hold = sink_quiet ? 0 : $urandom_range(0, 16);
			end
			if (sink_hold > 0) begin
				sink_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_size(input logic [0:0] idx, input logic [SIZE_W-1:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do
			@(negedge clk);
		while (!cfg_acc);
		cfg_valid <= 1'b0;
	endtask

	// wait for every pixel to go in and every result to come out, then a short tail
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pixels_taken != pixels_queued || smoothed_due.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// one whole frame at the current size
	task automatic run_frame(input fill_t fill);
		int unsigned w, h, n, i;
		logic [PIX_W-1:0] p;
		w = size_limit(width_reg, MAX_W);
		h = size_limit(height_reg, MAX_H);
		n = w * h;
		@(posedge clk);
		for (i = 0; i < n; i++) begin
			case (fill)
				FILL_FULL: p = 8'hFF;
				FILL_EMPTY: p = 8'h00;
				FILL_CHECKER: p = ((((i % w) + (i / w)) % 2) == 1) ? 8'hFF : 8'h00;
				default: begin
					if ($urandom_range(0, 7) == 0)
						p = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
					else
						p = $urandom_range(0, 255);
				end
			endcase
			pixel_backlog.push_back(p);
		end
		pixels_queued += n;
		wait_idle();
	endtask

	initial begin
		int unsigned i;
		int unsigned random_start;
		int unsigned pick;
		for (i = 0; i < MAX_W; i++) begin
			older_line[i] = '0;
			newer_line[i] = '0;
		end
		for (i = 0; i < 6; i++)
			win[i] = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// height left at reset, width below range clamps to three
		write_size(REG_WIDTH, 11'd0);
		run_frame(FILL_RANDOM);

		// smallest frame: saturated sums, all zero; then a 4x3 checkerboard
		write_size(REG_HEIGHT, 11'd1);
		run_frame(FILL_FULL);
		write_size(REG_WIDTH, 11'd2);
		write_size(REG_HEIGHT, 11'd3);
		run_frame(FILL_EMPTY);
		write_size(REG_WIDTH, 11'd4);
		run_frame(FILL_CHECKER);

		// random small frames, now and then a size below range
		random_start = pixels_queued;
		while (pixels_queued < random_start + RANDOM_PIXELS) begin
			pick = $urandom_range(0, 3);
			if (pick != 0)
				write_size(REG_WIDTH, SIZE_W'(($urandom_range(0, 9) == 0) ?
					$urandom_range(0, 2) : $urandom_range(3, 12)));
			if (pick != 1)
				write_size(REG_HEIGHT, SIZE_W'(($urandom_range(0, 9) == 0) ?
					$urandom_range(0, 2) : $urandom_range(3, 8)));
			run_frame(FILL_RANDOM);
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
